### sv/mmp_pkg.sv
// mmp_pkg: shared constants, configuration record and codes for the mosaic block
// no dependencies; used by masked_mosaic_pixelation, mmp_front and mmp_back
package mmp_pkg;

	localparam int MAX_FRAME_SIDE = 4096;
	localparam int MAX_GRID_SIDE  = 64;
	localparam int MIN_BLOCK      = 16;
	localparam int QUEUE_DEPTH    = 4;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_GRID_WIDTH   = 3'd2,
		CFG_GRID_HEIGHT  = 3'd3,
		CFG_BLOCK_SIZE   = 3'd4,
		CFG_INVERT_MASK  = 3'd5
	} cfg_index_t;

	// reset values of the registers
	localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
	localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
	localparam logic [7:0]  RST_BLOCK_SIZE   = 8'd16;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [6:0]  grid_width;
		logic [6:0]  grid_height;
		logic [7:0]  block_size;
		logic        invert_mask;
	} cfg_t;

	// front sequencer states
	typedef enum logic [3:0] {
		FE_INIT = 4'b0001,
		FE_DIV  = 4'b0010,
		FE_WALK = 4'b0100,
		FE_RUN  = 4'b1000
	} fe_state_t;

endpackage

### sv/masked_mosaic_pixelation.sv
// masked_mosaic_pixelation: top level, configuration registers, front, queue and back
// depends on mmp_pkg, mmp_front, mmp_queue, mmp_back
//
//   channel  handshake                 payload
//   in       in_valid / in_stall       mode cell_address cell_value pixel_in frame_start
//   out      out_valid / out_stall     pixel_out was_masked frame_end
//   cfg      cfg_we                    cfg_index cfg_data
//
// one item per clock while in_stall is low; a pixel passes the queue and stage 1 before the output register
// mask writes give no beat on the output channel
// after reset and after every register write the front rebuilds its counters: it loads the
// grid sides, divides them by the frame sides, then walks the counters up to the held position;
// in_stall is high throughout
// a four entry queue parts the front from the back, so out_stall reaches in_stall only when full
module masked_mosaic_pixelation #(
	parameter int MAX_FRAME_SIDE = mmp_pkg::MAX_FRAME_SIDE,
	parameter int MAX_GRID_SIDE  = mmp_pkg::MAX_GRID_SIDE,
	parameter int MIN_BLOCK      = mmp_pkg::MIN_BLOCK
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [11:0] cell_address,
	input  logic        cell_value,
	input  logic [7:0]  pixel_in,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pixel_out,
	output logic        was_masked,
	output logic        frame_end
);

	localparam int LD = MAX_FRAME_SIDE / MIN_BLOCK + 1;
	localparam int LW = $clog2(LD);
	localparam int MD = MAX_GRID_SIDE * MAX_GRID_SIDE;
	localparam int MW = $clog2(MD);
	localparam int EW = MW + LW + 13;

	mmp_pkg::cfg_t cfg_q;

	logic          push, q_full, q_empty, pop;
	logic [EW-1:0] q_din, q_dout;
	logic          e_mode, e_wval, e_org, e_en, e_fend;
	logic [MW-1:0] e_addr;
	logic [7:0]    e_pix;
	logic [LW-1:0] e_lcol;
	logic          h_mode, h_wval, h_org, h_en, h_fend;
	logic [MW-1:0] h_addr;
	logic [7:0]    h_pix;
	logic [LW-1:0] h_lcol;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= mmp_pkg::RST_FRAME_WIDTH;
			cfg_q.frame_height <= mmp_pkg::RST_FRAME_HEIGHT;
			cfg_q.grid_width   <= '0;
			cfg_q.grid_height  <= '0;
			cfg_q.block_size   <= mmp_pkg::RST_BLOCK_SIZE;
			cfg_q.invert_mask  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mmp_pkg::CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				mmp_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				mmp_pkg::CFG_GRID_WIDTH:   cfg_q.grid_width   <= cfg_data[6:0];
				mmp_pkg::CFG_GRID_HEIGHT:  cfg_q.grid_height  <= cfg_data[6:0];
				mmp_pkg::CFG_BLOCK_SIZE:   cfg_q.block_size   <= cfg_data[7:0];
				mmp_pkg::CFG_INVERT_MASK:  cfg_q.invert_mask  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	mmp_front #(
		.MAX_FRAME_SIDE (MAX_FRAME_SIDE),
		.MAX_GRID_SIDE  (MAX_GRID_SIDE),
		.MIN_BLOCK      (MIN_BLOCK)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cfg_we       (cfg_we),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.cell_address (cell_address),
		.cell_value   (cell_value),
		.pixel_in     (pixel_in),
		.frame_start  (frame_start),
		.q_full       (q_full),
		.push         (push),
		.e_mode       (e_mode),
		.e_addr       (e_addr),
		.e_wval       (e_wval),
		.e_pix        (e_pix),
		.e_lcol       (e_lcol),
		.e_org        (e_org),
		.e_en         (e_en),
		.e_fend       (e_fend)
	);

	// queue entry packing
	assign q_din = {e_mode, e_addr, e_wval, e_pix, e_lcol, e_org, e_en, e_fend};
	assign {h_mode, h_addr, h_wval, h_pix, h_lcol, h_org, h_en, h_fend} = q_dout;

	mmp_queue #(.WIDTH(EW), .DEPTH(mmp_pkg::QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	mmp_back #(
		.MAX_FRAME_SIDE (MAX_FRAME_SIDE),
		.MAX_GRID_SIDE  (MAX_GRID_SIDE),
		.MIN_BLOCK      (MIN_BLOCK)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.invert     (cfg_q.invert_mask),
		.q_empty    (q_empty),
		.pop        (pop),
		.h_mode     (h_mode),
		.h_addr     (h_addr),
		.h_wval     (h_wval),
		.h_pix      (h_pix),
		.h_lcol     (h_lcol),
		.h_org      (h_org),
		.h_en       (h_en),
		.h_fend     (h_fend),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.was_masked (was_masked),
		.frame_end  (frame_end)
	);

endmodule

### sv/mmp_ram.sv
// mmp_ram: generic single write port, single read port memory with registered read
// no dependencies
module mmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, old data on collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/mmp_queue.sv
// mmp_queue: small register fifo between the front and the back
// no dependencies
module mmp_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = data_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/mmp_front.sv
// mmp_front: accepts items, keeps pixel position and incremental block and grid counters
// depends on mmp_pkg
module mmp_front #(
	parameter int MAX_FRAME_SIDE = mmp_pkg::MAX_FRAME_SIDE,
	parameter int MAX_GRID_SIDE  = mmp_pkg::MAX_GRID_SIDE,
	parameter int MIN_BLOCK      = mmp_pkg::MIN_BLOCK,
	localparam int FW  = $clog2(MAX_FRAME_SIDE) + 1,
	localparam int XW  = FW - 1,
	localparam int GW  = $clog2(MAX_GRID_SIDE) + 1,
	localparam int GIW = GW - 1,
	localparam int QW  = XW + GW,
	localparam int LD  = MAX_FRAME_SIDE / MIN_BLOCK + 1,
	localparam int LW  = $clog2(LD),
	localparam int MD  = MAX_GRID_SIDE * MAX_GRID_SIDE,
	localparam int MW  = $clog2(MD)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mmp_pkg::cfg_t  cfg,
	input  logic           cfg_we,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           mode,
	input  logic [11:0]    cell_address,
	input  logic           cell_value,
	input  logic [7:0]     pixel_in,
	input  logic           frame_start,
	input  logic           q_full,
	output logic           push,
	output logic           e_mode,
	output logic [MW-1:0]  e_addr,
	output logic           e_wval,
	output logic [7:0]     e_pix,
	output logic [LW-1:0]  e_lcol,
	output logic           e_org,
	output logic           e_en,
	output logic           e_fend
);

	mmp_pkg::fe_state_t st_q;

	logic [FW-1:0] w, h;
	logic [GW-1:0] gw, gh;
	logic [7:0]    bs;

	logic [XW-1:0] x_q, y_q, wx_q, wy_q;
	logic [7:0]    cph_q, rph_q;
	logic [LW-1:0] col_q;
	logic [QW-1:0] cq_q, rq_q;
	logic [FW-1:0] cr_q, rr_q;
	logic [GW-1:0] cdv_q, rdv_q, csq_q, rsq_q;

	logic          acc, use_base, row_end, fend;
	logic [FW-1:0] bcr, brr;
	logic [QW-1:0] brq;
	logic [XW-1:0] c_x, c_y;
	logic [7:0]    c_cph, c_rph, n_cph, n_rph;
	logic [LW-1:0] c_col, n_col;
	logic [QW-1:0] c_cq, c_rq, n_cq, n_rq;
	logic [FW-1:0] c_cr, c_rr, n_cr, n_rr;
	logic [FW:0]   cr_sum, rr_sum;
	logic [7:0]    cph_inc, rph_inc;
	logic [GIW-1:0] ccl, rcl;
	logic          cdiv_done, rdiv_done;

	// used register values
	always_comb begin
		if (cfg.frame_width == '0) begin
			w = FW'(1);
		end else if (32'(cfg.frame_width) > MAX_FRAME_SIDE) begin
			w = FW'(MAX_FRAME_SIDE);
		end else begin
			w = FW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			h = FW'(1);
		end else if (32'(cfg.frame_height) > MAX_FRAME_SIDE) begin
			h = FW'(MAX_FRAME_SIDE);
		end else begin
			h = FW'(cfg.frame_height);
		end
		gw = (32'(cfg.grid_width) > MAX_GRID_SIDE) ? GW'(MAX_GRID_SIDE) : GW'(cfg.grid_width);
		gh = (32'(cfg.grid_height) > MAX_GRID_SIDE) ? GW'(MAX_GRID_SIDE) : GW'(cfg.grid_height);
		bs = (32'(cfg.block_size) < MIN_BLOCK) ? 8'(MIN_BLOCK) : cfg.block_size;
	end

	// dda remainder at position zero
	assign bcr = (gw != '0 && 32'(gw) < 32'(w)) ? FW'(32'(gw) - 1) : '0;

	// row dda at position zero follows the column test: gh - 1 split by h, or zero
	assign brr = (gh != '0 && 32'(gw) < 32'(w))
		? ((rdv_q != '0) ? FW'(rdv_q - 1'b1) : FW'(32'(h) - 1)) : '0;
	assign brq = (gh == '0 || 32'(gw) >= 32'(w)) ? '0
		: ((rdv_q != '0) ? QW'(rsq_q) : QW'(rsq_q) - 1'b1);

	assign in_stall = (st_q != mmp_pkg::FE_RUN) || q_full;
	assign acc      = in_valid && !in_stall;
	assign use_base = (st_q == mmp_pkg::FE_RUN) && frame_start;

	// counters seen by this pixel
	always_comb begin
		c_x   = use_base ? '0 : x_q;
		c_y   = use_base ? '0 : y_q;
		c_cph = use_base ? '0 : cph_q;
		c_col = use_base ? '0 : col_q;
		c_cq  = use_base ? '0 : cq_q;
		c_cr  = use_base ? bcr : cr_q;
		c_rph = use_base ? '0 : rph_q;
		c_rq  = use_base ? brq : rq_q;
		c_rr  = use_base ? brr : rr_q;
	end

	// one column step of block phase and grid dda
	always_comb begin
		cph_inc = c_cph + 8'd1;
		n_cph   = (cph_inc == bs) ? 8'd0 : cph_inc;
		n_col   = (cph_inc == bs) ? c_col + 1'b1 : c_col;
		cr_sum  = {1'b0, c_cr} + (FW+1)'(cdv_q);
		if (cr_sum >= {1'b0, w}) begin
			n_cr = FW'(cr_sum - {1'b0, w});
			n_cq = c_cq + QW'(csq_q) + 1'b1;
		end else begin
			n_cr = FW'(cr_sum);
			n_cq = c_cq + QW'(csq_q);
		end
	end

	// one row step of block phase and grid dda
	always_comb begin
		rph_inc = c_rph + 8'd1;
		n_rph   = (rph_inc == bs) ? 8'd0 : rph_inc;
		rr_sum  = {1'b0, c_rr} + (FW+1)'(rdv_q);
		if (rr_sum >= {1'b0, h}) begin
			n_rr = FW'(rr_sum - {1'b0, h});
			n_rq = c_rq + QW'(rsq_q) + 1'b1;
		end else begin
			n_rr = FW'(rr_sum);
			n_rq = c_rq + QW'(rsq_q);
		end
	end

	assign row_end   = 32'(c_x) >= 32'(w) - 1;
	assign fend      = row_end && (32'(c_y) >= 32'(h) - 1);
	assign cdiv_done = 32'(cdv_q) < 32'(w);
	assign rdiv_done = 32'(rdv_q) < 32'(h);

	// grid cell, indices held to the last row and column
	always_comb begin
		if (gw == '0 || 32'(c_cq) > 32'(gw) - 1) begin
			ccl = (gw == '0) ? '0 : GIW'(32'(gw) - 1);
		end else begin
			ccl = GIW'(c_cq);
		end
		if (gh == '0 || 32'(c_rq) > 32'(gh) - 1) begin
			rcl = (gh == '0) ? '0 : GIW'(32'(gh) - 1);
		end else begin
			rcl = GIW'(c_rq);
		end
	end

	// queue entry
	always_comb begin
		push   = acc && (mode || (32'(cell_address) < MD));
		e_mode = mode;
		e_addr = mode ? (MW'(rcl) * MW'(gw) + MW'(ccl)) : MW'(cell_address);
		e_wval = cell_value;
		e_pix  = pixel_in;
		e_lcol = c_col;
		e_org  = (c_cph == 8'd0) && (c_rph == 8'd0);
		e_en   = (gw != '0) && (gh != '0);
		e_fend = fend;
	end

	// sequencer: rebuild counters after reset or a register write, then run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= mmp_pkg::FE_INIT;
			x_q   <= '0;
			y_q   <= '0;
			wx_q  <= '0;
			wy_q  <= '0;
			cph_q <= '0;
			rph_q <= '0;
			col_q <= '0;
			cq_q  <= '0;
			rq_q  <= '0;
			cr_q  <= '0;
			rr_q  <= '0;
			cdv_q <= '0;
			rdv_q <= '0;
			csq_q <= '0;
			rsq_q <= '0;
		end else if (cfg_we) begin
			st_q <= mmp_pkg::FE_INIT;
		end else begin
			case (st_q)
				mmp_pkg::FE_INIT: begin
					cdv_q <= gw;
					rdv_q <= gh;
					csq_q <= '0;
					rsq_q <= '0;
					st_q  <= mmp_pkg::FE_DIV;
				end
				mmp_pkg::FE_DIV: begin
					// split the grid side into whole frame steps and a remainder
					if (!cdiv_done) begin
						cdv_q <= GW'(32'(cdv_q) - 32'(w));
						csq_q <= csq_q + 1'b1;
					end
					if (!rdiv_done) begin
						rdv_q <= GW'(32'(rdv_q) - 32'(h));
						rsq_q <= rsq_q + 1'b1;
					end
					if (cdiv_done && rdiv_done) begin
						cph_q <= '0;
						col_q <= '0;
						cq_q  <= '0;
						cr_q  <= bcr;
						rph_q <= '0;
						rq_q  <= brq;
						rr_q  <= brr;
						wx_q  <= '0;
						wy_q  <= '0;
						st_q  <= mmp_pkg::FE_WALK;
					end
				end
				mmp_pkg::FE_WALK: begin
					// step counters up to the held position
					if (wx_q != x_q) begin
						wx_q  <= wx_q + 1'b1;
						cph_q <= n_cph;
						col_q <= n_col;
						cq_q  <= n_cq;
						cr_q  <= n_cr;
					end
					if (wy_q != y_q) begin
						wy_q  <= wy_q + 1'b1;
						rph_q <= n_rph;
						rq_q  <= n_rq;
						rr_q  <= n_rr;
					end
					if (wx_q == x_q && wy_q == y_q) begin
						st_q <= mmp_pkg::FE_RUN;
					end
				end
				mmp_pkg::FE_RUN: begin
					if (acc && mode) begin
						if (row_end) begin
							x_q   <= '0;
							cph_q <= '0;
							col_q <= '0;
							cq_q  <= '0;
							cr_q  <= bcr;
							if (fend) begin
								y_q   <= '0;
								rph_q <= '0;
								rq_q  <= brq;
								rr_q  <= brr;
							end else begin
								y_q   <= c_y + 1'b1;
								rph_q <= n_rph;
								rq_q  <= n_rq;
								rr_q  <= n_rr;
							end
						end else begin
							x_q   <= c_x + 1'b1;
							cph_q <= n_cph;
							col_q <= n_col;
							cq_q  <= n_cq;
							cr_q  <= n_cr;
							y_q   <= c_y;
							rph_q <= c_rph;
							rq_q  <= c_rq;
							rr_q  <= c_rr;
						end
					end
				end
				default: begin
					st_q <= mmp_pkg::FE_INIT;
				end
			endcase
		end
	end

endmodule

### sv/mmp_back.sv
// mmp_back: mask store, block origin line store, pixel select and output register
// depends on mmp_pkg and mmp_ram
module mmp_back #(
	parameter int MAX_FRAME_SIDE = mmp_pkg::MAX_FRAME_SIDE,
	parameter int MAX_GRID_SIDE  = mmp_pkg::MAX_GRID_SIDE,
	parameter int MIN_BLOCK      = mmp_pkg::MIN_BLOCK,
	localparam int LD = MAX_FRAME_SIDE / MIN_BLOCK + 1,
	localparam int LW = $clog2(LD),
	localparam int MD = MAX_GRID_SIDE * MAX_GRID_SIDE,
	localparam int MW = $clog2(MD)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          invert,
	input  logic          q_empty,
	output logic          pop,
	input  logic          h_mode,
	input  logic [MW-1:0] h_addr,
	input  logic          h_wval,
	input  logic [7:0]    h_pix,
	input  logic [LW-1:0] h_lcol,
	input  logic          h_org,
	input  logic          h_en,
	input  logic          h_fend,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    pixel_out,
	output logic          was_masked,
	output logic          frame_end
);

	logic          s1_v_q;
	logic          mode_s1, wval_s1, org_s1, en_s1, fend_s1;
	logic [MW-1:0] addr_s1;
	logic [7:0]    pix_s1;
	logic [LW-1:0] lcol_s1;
	logic          flv_s1, fmv_s1, fmd_s1;
	logic [7:0]    fld_s1;

	logic          s1_adv, lwe, mwe;
	logic [7:0]    line_rd, origin, res;
	logic          mask_rd, bit_v, masked;

	assign s1_adv = s1_v_q && (!mode_s1 || !out_valid || !out_stall);
	assign pop    = !q_empty && (!s1_v_q || s1_adv);
	assign lwe    = s1_adv && mode_s1 && org_s1;
	assign mwe    = s1_adv && !mode_s1;

	mmp_ram #(.WIDTH(8), .DEPTH(LD)) u_line (
		.clk   (clk),
		.we    (lwe),
		.waddr (lcol_s1),
		.wdata (pix_s1),
		.re    (pop),
		.raddr (h_lcol),
		.rdata (line_rd)
	);

	mmp_ram #(.WIDTH(1), .DEPTH(MD)) u_mask (
		.clk   (clk),
		.we    (mwe),
		.waddr (addr_s1),
		.wdata (wval_s1),
		.re    (pop),
		.raddr (h_addr),
		.rdata (mask_rd)
	);

	// stage 1 payload with forwarding of a write made at the read edge
	always_ff @(posedge clk) begin
		if (pop) begin
			mode_s1 <= h_mode;
			addr_s1 <= h_addr;
			wval_s1 <= h_wval;
			pix_s1  <= h_pix;
			lcol_s1 <= h_lcol;
			org_s1  <= h_org;
			en_s1   <= h_en;
			fend_s1 <= h_fend;
			flv_s1  <= lwe && (lcol_s1 == h_lcol);
			fld_s1  <= pix_s1;
			fmv_s1  <= mwe && (addr_s1 == h_addr);
			fmd_s1  <= wval_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (pop) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	// pixel select
	always_comb begin
		origin = org_s1 ? pix_s1 : (flv_s1 ? fld_s1 : line_rd);
		bit_v  = fmv_s1 ? fmd_s1 : mask_rd;
		masked = en_s1 && (bit_v ^ invert);
		res    = masked ? origin : pix_s1;
	end

	// output register
	always_ff @(posedge clk) begin
		if (s1_adv && mode_s1) begin
			pixel_out  <= res;
			was_masked <= masked;
			frame_end  <= fend_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv && mode_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

endmodule

### sv/mmp_checker.sv
// mmp_checker: port level checks of masked_mosaic_pixelation, bound to the top level
// no package dependencies
module mmp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pixel_out,
	input logic       was_masked,
	input logic       frame_end
);

	// counter rebuild holds the input off right after reset
	a_stall_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> in_stall)
		else $error("input taken before counter rebuild after reset");

	// a register write starts a rebuild
	a_stall_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken right after a register write");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out)
			&& $stable(was_masked) && $stable(frame_end))
		else $error("stalled output beat changed");

endmodule

bind masked_mosaic_pixelation mmp_checker u_mmp_checker (.*);
